// ===== rtl/rtc_bcd_datetime_decoder_defines.svh =====
// ----------------------------------------------------------------------------
// RTC BCD date/time decoder assertion macros
// Shared concurrent assertion forms, clocked on clk with rst_n as disable.
// ----------------------------------------------------------------------------
`ifndef RTC_BCD_DATETIME_DECODER_DEFINES_SVH
`define RTC_BCD_DATETIME_DECODER_DEFINES_SVH

// same-cycle implication
`define RTCBCD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RTCBCD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rtcbcd_pkg.sv =====
// ----------------------------------------------------------------------------
// RTC BCD decoder package
// Shared types, masks, lane indexes and the month-length table.
// ----------------------------------------------------------------------------
package rtcbcd_pkg;

    localparam int NUM_LANES = 7;

    localparam int LANE_SEC   = 0;
    localparam int LANE_MIN   = 1;
    localparam int LANE_HOUR  = 2;
    localparam int LANE_DAY   = 3;
    localparam int LANE_WDAY  = 4;
    localparam int LANE_MONTH = 5;
    localparam int LANE_YEAR  = 6;

    localparam logic [7:0] MASK_SEC   = 8'h7f;
    localparam logic [7:0] MASK_MIN   = 8'h7f;
    localparam logic [7:0] MASK_HOUR  = 8'h3f;
    localparam logic [7:0] MASK_DAY   = 8'h3f;
    localparam logic [7:0] MASK_WDAY  = 8'h07;
    localparam logic [7:0] MASK_MONTH = 8'h1f;
    localparam logic [7:0] MASK_YEAR  = 8'hff;
    localparam logic [7:0] OSC_STOP   = 8'h80;

    localparam logic [11:0] BASE_1970 = 12'd1970;
    localparam logic [11:0] BASE_2000 = 12'd2000;
    localparam logic [11:0] YEAR_MIN  = 12'd1970;
    localparam logic [11:0] YEAR_MAX  = 12'd2069;
    localparam logic [11:0] EPOCH_RST = 12'd2000;

    typedef struct packed {
        logic       ok;
        logic [6:0] bin;
    } lane_t;

    typedef struct packed {
        logic        date_ok;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [2:0]  weekday;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } result_t;

    function automatic logic [4:0] month_len(input logic [3:0] mo);
        logic [4:0] len;
        case (mo)
            4'd1:    len = 5'd31;
            4'd2:    len = 5'd28;
            4'd3:    len = 5'd31;
            4'd4:    len = 5'd30;
            4'd5:    len = 5'd31;
            4'd6:    len = 5'd30;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd31;
            4'd9:    len = 5'd30;
            4'd10:   len = 5'd31;
            4'd11:   len = 5'd30;
            4'd12:   len = 5'd31;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

// ===== rtl/rtcbcd_lane.sv =====
// ----------------------------------------------------------------------------
// RTC BCD decoder lane
// Masks one register byte, checks both BCD digits and converts to binary.
// ----------------------------------------------------------------------------
module rtcbcd_lane
    import rtcbcd_pkg::*;
(
    input  logic [7:0] raw,
    input  logic [7:0] mask,
    output lane_t      lane
);

    logic [7:0] masked;
    logic [3:0] lo;
    logic [3:0] hi;

    assign masked = raw & mask;
    assign lo     = masked[3:0];
    assign hi     = masked[7:4];

    assign lane.ok  = (lo <= 4'd9) && (hi <= 4'd9);
    assign lane.bin = ({3'b000, hi} << 3) + ({3'b000, hi} << 1) + {3'b000, lo};

endmodule

// ===== rtl/rtcbcd_merge.sv =====
// ----------------------------------------------------------------------------
// RTC BCD decoder merge stage
// Combines lane results, forms the full year and checks the calendar.
// ----------------------------------------------------------------------------
module rtcbcd_merge
    import rtcbcd_pkg::*;
(
    input  lane_t       lanes [NUM_LANES],
    input  logic        osc_stop,
    input  logic [11:0] epoch_year,
    output result_t     res
);

    logic        digits_ok;
    logic        base_ok;
    logic [11:0] full_year;
    logic [6:0]  mo;
    logic [6:0]  d;
    logic [4:0]  lim;
    logic        range_ok;
    logic        ok;

    always_comb
    begin
        digits_ok = 1'b1;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            digits_ok = digits_ok & lanes[i].ok;
        end
    end

    assign base_ok   = (epoch_year == BASE_1970) || (epoch_year == BASE_2000);
    assign full_year = epoch_year + {5'b00000, lanes[LANE_YEAR].bin};
    assign mo        = lanes[LANE_MONTH].bin;
    assign d         = lanes[LANE_DAY].bin;
    assign lim       = month_len(mo[3:0])
                     + {4'b0000, (mo == 7'd2) && (full_year[1:0] == 2'b00)};

    assign range_ok = (full_year >= YEAR_MIN) && (full_year <= YEAR_MAX)
                   && (mo != 7'd0) && (mo <= 7'd12)
                   && (d != 7'd0) && (d <= {2'b00, lim})
                   && (lanes[LANE_WDAY].bin <= 7'd6)
                   && (lanes[LANE_HOUR].bin <= 7'd23)
                   && (lanes[LANE_MIN].bin <= 7'd59)
                   && (lanes[LANE_SEC].bin <= 7'd59);

    assign ok = !osc_stop && base_ok && digits_ok && range_ok;

    always_comb
    begin
        res = '0;
        if (ok)
        begin
            res.date_ok = 1'b1;
            res.year    = full_year;
            res.month   = mo[3:0];
            res.day     = d[4:0];
            res.weekday = lanes[LANE_WDAY].bin[2:0];
            res.hour    = lanes[LANE_HOUR].bin[4:0];
            res.minute  = lanes[LANE_MIN].bin[5:0];
            res.second  = lanes[LANE_SEC].bin[5:0];
        end
    end

endmodule

// ===== rtl/rtc_bcd_datetime_decoder.sv =====
// ----------------------------------------------------------------------------
// RTC BCD date/time decoder
// Decodes a seven-byte RTC time block into checked binary date and time.
// ----------------------------------------------------------------------------
// Accepts one time block per clock cycle while in_ready is high; the decoded
// result is registered in the output register, or in the skid register if
// the output stalls. Seven BCD lanes decode the bytes in parallel and a merge
// stage checks the calendar combinationally. A two-entry output buffer
// (output register plus skid register) keeps in_ready high while one result
// waits; in_ready falls only when both entries are full. The epoch year
// register resets to 2000; any value other than 1970 or 2000 makes every
// block decode as rejected (date_ok low, all fields zero).
module rtc_bcd_datetime_decoder
    import rtcbcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [11:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  seconds_byte,
    input  logic [7:0]  minutes_byte,
    input  logic [7:0]  hours_byte,
    input  logic [7:0]  day_byte,
    input  logic [7:0]  weekday_byte,
    input  logic [7:0]  month_byte,
    input  logic [7:0]  year_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        date_ok,
    output logic [11:0] year,
    output logic [3:0]  month,
    output logic [4:0]  day,
    output logic [2:0]  weekday,
    output logic [4:0]  hour,
    output logic [5:0]  minute,
    output logic [5:0]  second
);

    logic [11:0] epoch_reg;
    logic        out_valid_reg;
    logic        skid_valid_reg;
    result_t     out_reg;
    result_t     skid_reg;

    logic [7:0]  raw   [NUM_LANES];
    logic [7:0]  masks [NUM_LANES];
    lane_t       lanes [NUM_LANES];
    result_t     res;
    logic        in_fire;
    logic        out_fire;
    logic        out_stall;
    logic        year_in_range;

    assign raw[LANE_SEC]   = seconds_byte;
    assign raw[LANE_MIN]   = minutes_byte;
    assign raw[LANE_HOUR]  = hours_byte;
    assign raw[LANE_DAY]   = day_byte;
    assign raw[LANE_WDAY]  = weekday_byte;
    assign raw[LANE_MONTH] = month_byte;
    assign raw[LANE_YEAR]  = year_byte;

    assign masks[LANE_SEC]   = MASK_SEC;
    assign masks[LANE_MIN]   = MASK_MIN;
    assign masks[LANE_HOUR]  = MASK_HOUR;
    assign masks[LANE_DAY]   = MASK_DAY;
    assign masks[LANE_WDAY]  = MASK_WDAY;
    assign masks[LANE_MONTH] = MASK_MONTH;
    assign masks[LANE_YEAR]  = MASK_YEAR;

    for (genvar g = 0; g < NUM_LANES; g++)
    begin : g_lane
        rtcbcd_lane u_lane (
            .raw  (raw[g]),
            .mask (masks[g]),
            .lane (lanes[g])
        );
    end

    rtcbcd_merge u_merge (
        .lanes      (lanes),
        .osc_stop   ((seconds_byte & OSC_STOP) != 8'h00),
        .epoch_year (epoch_reg),
        .res        (res)
    );

    assign in_ready = !skid_valid_reg;
    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epoch_reg <= EPOCH_RST;
        end
        else if (cfg_wr_en)
        begin
            epoch_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_fire)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= in_fire;
            end
            else
            begin
                out_valid_reg <= in_fire;
            end
        end
        else if (in_fire)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_fire)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
                if (in_fire)
                begin
                    skid_reg <= res;
                end
            end
            else if (in_fire)
            begin
                out_reg <= res;
            end
        end
        else if (in_fire)
        begin
            skid_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign date_ok   = out_reg.date_ok;
    assign year      = out_reg.year;
    assign month     = out_reg.month;
    assign day       = out_reg.day;
    assign weekday   = out_reg.weekday;
    assign hour      = out_reg.hour;
    assign minute    = out_reg.minute;
    assign second    = out_reg.second;

    assign out_stall     = out_valid_reg && !out_ready;
    assign year_in_range = (year >= YEAR_MIN) && (year <= YEAR_MAX);

`include "rtc_bcd_datetime_decoder_defines.svh"

    `RTCBCD_ASSERT_NOW(a_skid_implies_out, skid_valid_reg, out_valid_reg, "skid without output")
    `RTCBCD_ASSERT_NEXT(a_stall_skid, out_stall && in_fire, skid_valid_reg, "transfer lost")
    `RTCBCD_ASSERT_NOW(a_reject_zero, out_valid_reg && !date_ok, out_reg == '0, "reject not zero")
    `RTCBCD_ASSERT_NOW(a_year_range, out_valid_reg && date_ok, year_in_range, "year out of range")

endmodule
